/* sv/stable_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shorthand for clocked assertions, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check a consequence at the clock edge after its trigger.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int          DEPTH_DEF    = 64;
    localparam logic [7:0]  LIMIT_RESET  = 8'd10;
    localparam logic [3:0]  VIP_PRIORITY = 4'd1;

    // command codes; code 3 behaves as a peek
    localparam logic [1:0]  CMD_ENQ = 2'd0;
    localparam logic [1:0]  CMD_DEQ = 2'd1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  priority_req;
        logic [31:0] tag;
        logic [31:0] stamp;
    } t_cmd_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] assigned_id;
        logic [3:0]  head_priority;
        logic [15:0] head_id;
        logic [31:0] head_tag;
        logic [31:0] head_stamp;
        logic        is_empty;
        logic        is_full;
        logic [6:0]  occupancy;
    } t_result_item;

    // one stored queue entry
    typedef struct packed {
        logic [3:0]  prio;
        logic [15:0] id;
        logic [31:0] tag;
        logic [31:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // read address selection
    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_TAIL = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    enq_start;
        logic    rej_full;
        logic    rej_empty;
        logic    head_rd;
        logic    head_out;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    wr_new;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_enq;
        logic count_zero;
        logic count_full;
        logic shift_more;
        logic pos_one;
    } t_dp_stat;

endpackage

/* sv/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable sorted-insertion priority queue with enqueue, dequeue and peek.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Beat carries
//  -------   ---------  ---------------------   -------------------------------
//  command   in         start & !busy           i_cmd_item (cmd, priority, tag,
//                                               stamp)
//  result    out        o_done, one cycle       o_result (status, ids, head,
//                                               level)
//  config    in         i_cfg_valid & ready     i_cfg_data (vip_id_limit)
//
//  Reject on full or empty: result the cycle after accept, busy never rises.
//  Peek and dequeue: busy in S_HEAD for the registered read of the head slot,
//  then the result is registered. Enqueue: result the cycle after accept;
//  busy while the insertion scan moves entries up one slot (one per cycle,
//  bound by the single RAM write port) and then writes the new entry.
//  Reset (i_rst_n low, synchronous) empties the queue and loads the limit of
//  ten; the entry RAM is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command channel
    input  logic         start,
    output logic         busy,
    input  t_cmd_item    i_cmd_item,
    // result channel
    output logic         o_done,
    output t_result_item o_result,
    // configuration channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cfg_we;

    // the limit register takes a write beat at any time
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // sequencer: decode accepted beats, run the head read and insertion scan
    spq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_dp_stat (dp_stat),
        .o_busy    (busy),
        .o_dp_cmd  (dp_cmd)
    );

    // storage, id counters and the result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_item (i_cmd_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_dp_cmd   (dp_cmd),
        .o_dp_stat  (dp_stat),
        .o_result   (o_result),
        .o_done     (o_done)
    );

endmodule

/* sv/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: accept, head read and insertion scan.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_dp_stat,
    output logic     o_busy,
    output t_dp_cmd  o_dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HEAD  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_PLACE = 4'b1000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state      = r_state;
        n_cmd        = '0;
        n_cmd.rd_sel = RD_HEAD;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_dp_stat.is_enq) begin
                        if (i_dp_stat.count_full) begin
                            n_cmd.rej_full = 1'b1;
                        end else begin
                            n_cmd.enq_start = 1'b1;
                            if (i_dp_stat.count_zero) begin
                                n_state = S_PLACE;
                            end else begin
                                n_cmd.rd_sel = RD_TAIL;
                                n_state      = S_SCAN;
                            end
                        end
                    end else if (i_dp_stat.count_zero) begin
                        n_cmd.rej_empty = 1'b1;
                    end else begin
                        n_cmd.head_rd = 1'b1;
                        n_state       = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_cmd.head_out = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                if (i_dp_stat.shift_more) begin
                    // move the entry up one slot and look one further down
                    n_cmd.wr_shift = 1'b1;
                    if (i_dp_stat.pos_one) begin
                        n_state = S_PLACE;
                    end else begin
                        n_cmd.rd_sel = RD_NEXT;
                    end
                end else begin
                    n_cmd.wr_new = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_PLACE: begin
                n_cmd.wr_new = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_dp_cmd = n_cmd;

endmodule

/* sv/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Circular entry store, id counters, head pointer and result register.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_assert.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd_item    i_cmd_item,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_data,
    input  t_dp_cmd      i_dp_cmd,
    output t_dp_stat     o_dp_stat,
    output t_result_item o_result,
    output logic         o_done
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_pos;
    t_entry        r_new;
    logic          r_is_deq;
    logic [7:0]    r_limit;
    logic [7:0]    r_vip;
    logic [15:0]   r_regular;
    t_result_item  r_result;
    logic          r_done;

    t_result_item  n_result;
    logic [CW-1:0] cnt_after;
    logic [CW+6:0] occ_wide;

    logic [7:0]    eff_limit;
    logic [15:0]   eff_regular;
    logic          vip_take;
    logic [7:0]    vip_next;
    logic [15:0]   reg_next;
    logic [15:0]   new_id;

    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    // logical slot to physical address, modulo DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] lpos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, lpos};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_entry = ram_rdata;

    // id selection; a same-cycle register write takes effect first
    assign eff_limit   = i_cfg_we ? i_cfg_data : r_limit;
    assign eff_regular = i_cfg_we ? {8'd0, i_cfg_data} : r_regular;
    assign vip_take    = (i_cmd_item.priority_req == VIP_PRIORITY) && (r_vip < eff_limit);
    assign vip_next    = r_vip + 8'd1;
    assign reg_next    = eff_regular + 16'd1;
    assign new_id      = vip_take ? {8'd0, vip_next} : reg_next;

    always_comb begin
        unique case (i_dp_cmd.rd_sel)
            RD_HEAD: ram_raddr = r_head;
            RD_TAIL: ram_raddr = phys(r_head, AW'(r_count - CW'(1)));
            RD_NEXT: ram_raddr = phys(r_head, AW'(r_pos - AW'(2)));
            default: ram_raddr = r_head;
        endcase
    end

    assign ram_we    = i_dp_cmd.wr_shift | i_dp_cmd.wr_new;
    assign ram_waddr = phys(r_head, r_pos);
    assign ram_wdata = i_dp_cmd.wr_shift ? ram_rdata : r_new;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_dp_stat.is_enq     = (i_cmd_item.cmd == CMD_ENQ);
    assign o_dp_stat.count_zero = (r_count == '0);
    assign o_dp_stat.count_full = (r_count == CW'(DEPTH));
    assign o_dp_stat.shift_more = (rd_entry.prio > r_new.prio);
    assign o_dp_stat.pos_one    = (r_pos == AW'(1));

    // result of this step
    always_comb begin
        n_result  = '0;
        cnt_after = r_count;
        unique if (i_dp_cmd.enq_start) begin
            n_result.status      = ST_OK;
            n_result.assigned_id = new_id;
            cnt_after            = r_count + CW'(1);
        end else if (i_dp_cmd.rej_full) begin
            n_result.status = ST_FULL;
        end else if (i_dp_cmd.rej_empty) begin
            n_result.status = ST_EMPTY;
        end else if (i_dp_cmd.head_out) begin
            n_result.status        = ST_OK;
            n_result.head_priority = rd_entry.prio;
            n_result.head_id       = rd_entry.id;
            n_result.head_tag      = rd_entry.tag;
            n_result.head_stamp    = rd_entry.stamp;
            if (r_is_deq) begin
                cnt_after = r_count - CW'(1);
            end
        end else begin
            n_result.status = ST_OK;
        end
        occ_wide           = (CW+7)'(cnt_after);
        n_result.is_empty  = (cnt_after == '0);
        n_result.is_full   = (cnt_after == CW'(DEPTH));
        n_result.occupancy = occ_wide[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_head    <= '0;
            r_limit   <= LIMIT_RESET;
            r_vip     <= '0;
            r_regular <= {8'd0, LIMIT_RESET};
            r_done    <= 1'b0;
        end else begin
            r_done <= i_dp_cmd.enq_start | i_dp_cmd.rej_full |
                      i_dp_cmd.rej_empty | i_dp_cmd.head_out;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            // an enqueue drawing a regular id already counts from the new limit
            if (i_dp_cmd.enq_start && !vip_take) begin
                r_regular <= reg_next;
            end else if (i_cfg_we) begin
                r_regular <= {8'd0, i_cfg_data};
            end
            if (i_dp_cmd.enq_start) begin
                r_count <= r_count + CW'(1);
                if (vip_take) begin
                    r_vip <= vip_next;
                end
            end
            if (i_dp_cmd.head_out && r_is_deq) begin
                r_count <= r_count - CW'(1);
                r_head  <= phys(r_head, AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (i_dp_cmd.enq_start) begin
            r_new.prio  <= i_cmd_item.priority_req;
            r_new.id    <= new_id;
            r_new.tag   <= i_cmd_item.tag;
            r_new.stamp <= i_cmd_item.stamp;
            r_pos       <= AW'(r_count);
        end else if (i_dp_cmd.wr_shift) begin
            r_pos <= r_pos - AW'(1);
        end
        if (i_dp_cmd.head_rd) begin
            r_is_deq <= (i_cmd_item.cmd == CMD_DEQ);
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

    `SPQ_ASSERT_HOLDS(a_count_bound, r_count <= CW'(DEPTH), "occupancy above depth")
    `SPQ_ASSERT_NEXT(a_pop_count, i_dp_cmd.head_out && r_is_deq,
        r_count == $past(r_count) - CW'(1), "dequeue did not drop occupancy by one")
    `SPQ_ASSERT_NEXT(a_shift_pos, i_dp_cmd.wr_shift,
        r_pos == $past(r_pos) - AW'(1), "insertion hole did not move down")

endmodule
